// ===== rtl/core/window_leveling_cost_search_defines.svh =====
// ----------------------------------------------------------------------------
// window leveling cost search assertion macros
// shared assertion helpers, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef WINDOW_LEVELING_COST_SEARCH_DEFINES_SVH
`define WINDOW_LEVELING_COST_SEARCH_DEFINES_SVH

// plain property check
`define WLCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication check, antecedent and consequent
`define WLCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/wlcs_pkg.sv =====
// ----------------------------------------------------------------------------
// window leveling cost search package
// item types, widths, sequencer states and the cost sentinel
// ----------------------------------------------------------------------------
package wlcs_pkg;

  localparam int unsigned HEIGHT_W = 32;
  localparam int unsigned COST_W   = 42;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned SUM_W    = 43;
  localparam int unsigned POS_W    = 32;

  localparam logic [SUM_W-1:0] COST_SENTINEL = SUM_W'(1) << COST_W;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                last_item;
  } wlcs_in_t;

  typedef struct packed {
    logic [COST_W-1:0] best_cost;
    logic [POS_W-1:0]  best_start;
    logic              found;
  } wlcs_out_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] value;
    logic [POS_W-1:0]    pos;
  } wlcs_cand_t;

  typedef enum logic {
    S_IDLE,
    S_DROP
  } wlcs_state_e;

endpackage

// ===== rtl/core/window_leveling_cost_search.sv =====
// ----------------------------------------------------------------------------
// window leveling cost search
// per window: sum minus length times minimum; keeps lowest cost and its start
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  input   | in  | in_valid_i / in_stall_o   | in_data_i   (height, last_item)
//  result  | out | out_valid_o / out_stall_i | out_data_o  (best_cost, best_start, found)
//  config  | in  | cfg_we_i                  | cfg_wdata_i (window_length)
//
//  an item is accepted in the idle state and pushed from the drop state; each minimum
//  candidate it retires (expired at the head or dominated at the tail) adds a step,
//  at most one per item on average, all through one read-modify-write of the
//  candidate memory; the cost compare runs in a registered stage behind the push
//  and overlaps the next item. reset needs no clearing pass; a stalled result holds
//  only the compare stage, inputs are still taken until that stage is full
// ----------------------------------------------------------------------------
`include "window_leveling_cost_search_defines.svh"

module window_leveling_cost_search #(
  parameter int unsigned WINDOW_MAX = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  wlcs_pkg::wlcs_in_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output wlcs_pkg::wlcs_out_t      out_data_o,
  input  logic                     cfg_we_i,
  input  logic [wlcs_pkg::LEN_W-1:0] cfg_wdata_i
);
  import wlcs_pkg::*;

  localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (32'(i) + 32'd1 >= 32'(WINDOW_MAX)) r = '0;
    else r = i + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == '0) r = AW'(WINDOW_MAX - 1);
    else r = i - AW'(1);
    return r;
  endfunction

  // memories
  logic [HEIGHT_W-1:0] ws_mem [WINDOW_MAX];
  wlcs_cand_t          cq_mem [WINDOW_MAX];

  wlcs_state_e         state_q, state_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [AW-1:0]       head_q, head_d;
  logic [AW-1:0]       tail_q, tail_d;
  logic [LEN_W-1:0]    cnt_q, cnt_d;
  logic [POS_W-1:0]    seen_q, seen_d;
  logic [AW-1:0]       ring_q, ring_d;
  logic [POS_W-1:0]    pos_q, pos_d;

  logic [HEIGHT_W-1:0] height_q;
  logic                last_q;

  logic [HEIGHT_W-1:0] ws_rdata_q;
  wlcs_cand_t          cq_head_rd_q, cq_tail_rd_q;
  logic [AW-1:0]       head_raddr_q, tail_raddr_q;
  logic                fwd_vld_q;
  logic [AW-1:0]       fwd_addr_q;
  wlcs_cand_t          fwd_data_q;

  logic                cs_vld_q;
  logic                cs_last_q;
  logic                cs_elig_q;
  logic [SUM_W-1:0]    cs_sum_q;
  logic [SUM_W-1:0]    cs_prod_q;
  logic [POS_W-1:0]    cs_start_q;

  logic [SUM_W-1:0]    best_cost_q;
  logic [POS_W-1:0]    best_start_q;

  logic                out_vld_q;
  wlcs_out_t           out_data_q;

  wlcs_cand_t          head_ent, tail_ent, push_ent;
  logic                expire, accept, drop, push, cs_go, cs_free;
  logic [HEIGHT_W-1:0] min_val;
  logic [SUM_W-1:0]    sum_new, cost_full;
  logic [POS_W-1:0]    seen_new;
  logic [COST_W-1:0]   cost;
  logic                better;
  logic [SUM_W-1:0]    best_upd_cost;
  logic [POS_W-1:0]    best_upd_start;
  logic [LEN_W-1:0]    cfg_len;

  // forwarding of the write made at the previous edge
  assign head_ent = (fwd_vld_q && head_raddr_q == fwd_addr_q) ? fwd_data_q : cq_head_rd_q;
  assign tail_ent = (fwd_vld_q && tail_raddr_q == fwd_addr_q) ? fwd_data_q : cq_tail_rd_q;

  assign expire  = (state_q == S_IDLE) && (cnt_q != '0) &&
                   ((pos_q - head_ent.pos) >= POS_W'(len_q));
  assign in_stall_o = (state_q != S_IDLE) || expire;
  assign accept  = in_valid_i && !in_stall_o;
  assign drop    = (state_q == S_DROP) && (cnt_q != '0) && (tail_ent.value >= height_q);
  assign cs_go   = cs_vld_q && (!cs_last_q || !out_vld_q || !out_stall_i);
  assign cs_free = !cs_vld_q || cs_go;
  assign push    = (state_q == S_DROP) && !drop && cs_free;

  assign min_val  = (cnt_q == '0) ? height_q : head_ent.value;
  assign sum_new  = sum_q - ((seen_q >= POS_W'(len_q)) ? SUM_W'(ws_rdata_q) : '0)
                    + SUM_W'(height_q);
  assign seen_new = (seen_q == '1) ? seen_q : seen_q + POS_W'(1);
  assign push_ent = '{value: height_q, pos: pos_q};

  always_comb begin
    if (cfg_wdata_i == '0) cfg_len = LEN_W'(1);
    else if (32'(cfg_wdata_i) > 32'(WINDOW_MAX)) cfg_len = LEN_W'(WINDOW_MAX);
    else cfg_len = cfg_wdata_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_DROP;
      end
      S_DROP: begin
        if (push) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequence state
  always_comb begin
    len_d  = len_q;
    sum_d  = sum_q;
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    seen_d = seen_q;
    ring_d = ring_q;
    pos_d  = pos_q;
    if (cfg_we_i) begin
      len_d  = cfg_len;
      sum_d  = '0;
      head_d = '0;
      tail_d = '0;
      cnt_d  = '0;
      seen_d = '0;
      ring_d = '0;
      pos_d  = '0;
    end else if (expire) begin
      head_d = idx_next(head_q);
      cnt_d  = cnt_q - LEN_W'(1);
    end else if (drop) begin
      tail_d = idx_prev(tail_q);
      cnt_d  = cnt_q - LEN_W'(1);
    end else if (push) begin
      if (last_q) begin
        sum_d  = '0;
        head_d = '0;
        tail_d = '0;
        cnt_d  = '0;
        seen_d = '0;
        ring_d = '0;
        pos_d  = '0;
      end else begin
        sum_d  = sum_new;
        tail_d = idx_next(tail_q);
        cnt_d  = cnt_q + LEN_W'(1);
        seen_d = seen_new;
        pos_d  = pos_q + POS_W'(1);
        if (32'(ring_q) + 32'd1 >= 32'(len_q)) ring_d = '0;
        else ring_d = ring_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= LEN_W'(1);
      sum_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      seen_q  <= '0;
      ring_q  <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      seen_q  <= seen_d;
      ring_q  <= ring_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      height_q <= in_data_i.height;
      last_q   <= in_data_i.last_item;
    end
  end

  // height ring
  always_ff @(posedge clk_i) begin
    if (push) ws_mem[ring_q] <= height_q;
    ws_rdata_q <= ws_mem[ring_q];
  end

  // minimum candidate deque
  always_ff @(posedge clk_i) begin
    if (push) cq_mem[tail_q] <= push_ent;
    cq_head_rd_q <= cq_mem[head_d];
    cq_tail_rd_q <= cq_mem[idx_prev(tail_d)];
    head_raddr_q <= head_d;
    tail_raddr_q <= idx_prev(tail_d);
    fwd_addr_q   <= tail_q;
    fwd_data_q   <= push_ent;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_vld_q <= 1'b0;
    end else begin
      fwd_vld_q <= push;
    end
  end

  // cost stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_vld_q <= 1'b0;
    end else if (push) begin
      cs_vld_q <= 1'b1;
    end else if (cs_go) begin
      cs_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cs_last_q  <= last_q;
      cs_elig_q  <= seen_new >= POS_W'(len_q);
      cs_sum_q   <= sum_new;
      cs_prod_q  <= SUM_W'(min_val) * SUM_W'(len_q);
      cs_start_q <= seen_new - POS_W'(len_q) + POS_W'(1);
    end
  end

  assign cost_full = cs_sum_q - cs_prod_q;
  assign cost      = cost_full[COST_W-1:0];
  assign better    = cs_elig_q && (SUM_W'(cost) < best_cost_q);

  always_comb begin
    best_upd_cost  = best_cost_q;
    best_upd_start = best_start_q;
    if (better) begin
      best_upd_cost  = SUM_W'(cost);
      best_upd_start = cs_start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cost_q  <= COST_SENTINEL;
      best_start_q <= '0;
    end else if (cfg_we_i || (cs_go && cs_last_q)) begin
      best_cost_q  <= COST_SENTINEL;
      best_start_q <= '0;
    end else if (cs_go) begin
      best_cost_q  <= best_upd_cost;
      best_start_q <= best_upd_start;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cs_go && cs_last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cs_go && cs_last_q) begin
      if (best_upd_cost != COST_SENTINEL) begin
        out_data_q.best_cost  <= best_upd_cost[COST_W-1:0];
        out_data_q.best_start <= best_upd_start;
        out_data_q.found      <= 1'b1;
      end else begin
        out_data_q.best_cost  <= '0;
        out_data_q.best_start <= '0;
        out_data_q.found      <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  `WLCS_ASSERT(a_cnt_le_len, cnt_q <= len_q, "candidate count above window length")
  `WLCS_ASSERT(a_best_bound, best_cost_q <= COST_SENTINEL, "best cost above sentinel")
  `WLCS_ASSERT_IMP(a_out_from_last, $rose(out_vld_q), $past(cs_vld_q && cs_last_q),
    "result without a last item in the cost stage")
  `WLCS_ASSERT_IMP(a_push_nonempty, push && !last_q && !cfg_we_i, ##1 cnt_q != '0,
    "deque empty after push")

endmodule

// ===== sim/window_leveling_cost_search_tb.sv =====
// ----------------------------------------------------------------------------
// window leveling cost search testbench
// streams height sequences through the block under several window lengths,
// predicts the best leveling cost and start of each sequence, and checks
// every result item in order, with random idling, stalls and a long hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import wlcs_pkg::*;

  localparam int unsigned WINDOW_MAX  = 1024;
  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  wlcs_in_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  wlcs_out_t         out_data_o;
  logic              cfg_we_i    = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i = '0;

  window_leveling_cost_search #(
    .WINDOW_MAX (WINDOW_MAX)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // predictor state
  logic [LEN_W-1:0]    length_reg;
  logic [HEIGHT_W-1:0] ring_heights [WINDOW_MAX];
  logic [SUM_W-1:0]    run_sum;
  logic [HEIGHT_W-1:0] min_vals [$];
  logic [POS_W-1:0]    min_posns [$];
  logic [POS_W-1:0]    seen_cnt;
  logic [SUM_W-1:0]    low_cost;
  logic [POS_W-1:0]    low_start;
  int unsigned         ring_slot;
  logic [POS_W-1:0]    stream_pos;

  wlcs_out_t pending_results [$];
  wlcs_out_t exp_r;

  int unsigned cycle_cnt     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned found_seen    = 0;
  int unsigned cfg_writes    = 0;
  bit          calm          = 1'b0;
  bit          hold_pending  = 1'b0;
  int unsigned hold_left;

  function automatic int unsigned eff_len();
    if (length_reg == 0) return 1;
    if (length_reg > WINDOW_MAX) return WINDOW_MAX;
    return length_reg;
  endfunction

  function automatic void clear_run();
    run_sum    = '0;
    min_vals.delete();
    min_posns.delete();
    seen_cnt   = '0;
    low_cost   = COST_SENTINEL;
    low_start  = '0;
    ring_slot  = 0;
    stream_pos = '0;
  endfunction

  function automatic void level_config(input logic [LEN_W-1:0] v);
    length_reg = v;
    clear_run();
  endfunction

  function automatic void level_step(input logic [HEIGHT_W-1:0] h, input logic last);
    int unsigned      len;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] age;
    logic [SUM_W-1:0] prod;
    logic [SUM_W-1:0] cost;
    wlcs_out_t        res;
    len = eff_len();
    p   = stream_pos;
    if (ring_slot >= len) ring_slot = 0;
    if (seen_cnt >= len) run_sum = run_sum - SUM_W'(ring_heights[ring_slot]);
    ring_heights[ring_slot] = h;
    run_sum   = run_sum + SUM_W'(h);
    ring_slot = (ring_slot + 1 >= len) ? 0 : ring_slot + 1;
    while (min_posns.size() != 0) begin
      age = p - min_posns[0];
      if (age < len) break;
      void'(min_posns.pop_front());
      void'(min_vals.pop_front());
    end
    while (min_vals.size() != 0 && min_vals[$] >= h) begin
      void'(min_posns.pop_back());
      void'(min_vals.pop_back());
    end
    min_vals.push_back(h);
    min_posns.push_back(p);
    if (seen_cnt != '1) seen_cnt = seen_cnt + 1;
    stream_pos = p + 1;
    if (seen_cnt >= len) begin
      prod = SUM_W'(len) * SUM_W'(min_vals[0]);
      cost = run_sum - prod;
      cost[SUM_W-1] = 1'b0;
      if (cost < low_cost) begin
        low_cost  = cost;
        low_start = seen_cnt - POS_W'(len) + 1;
      end
    end
    if (last) begin
      if (low_cost != COST_SENTINEL) begin
        res.best_cost  = low_cost[COST_W-1:0];
        res.best_start = low_start;
        res.found      = 1'b1;
      end else begin
        res = '0;
      end
      pending_results.push_back(res);
      clear_run();
    end
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom();
    if (r < 75) return $urandom_range(7);
    if (r < 88) return 32'hFFFF_FFFF - $urandom_range(7);
    if (r < 94) return '0;
    return '1;
  endfunction

  task automatic send_item(input logic [HEIGHT_W-1:0] h, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < 15) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i          <= 1'b1;
    in_data_i.height    <= h;
    in_data_i.last_item <= last;
    do @(posedge clk_i); while (in_stall_o);
    level_step(h, last);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * eff_len() + 16) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    level_config(v);
    cfg_writes++;
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
        while (hold_left != 0) begin
          out_stall_i <= 1'b1;
          hold_left--;
          @(posedge clk_i);
        end
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 15);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result item with no expectation");
        fail_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.found) found_seen++;
        if (out_data_o.best_cost !== exp_r.best_cost) begin
          $error("best_cost: expected %0d, got %0d", exp_r.best_cost, out_data_o.best_cost);
          fail_cnt++;
        end
        if (out_data_o.best_start !== exp_r.best_start) begin
          $error("best_start: expected %0d, got %0d", exp_r.best_start,
                 out_data_o.best_start);
          fail_cnt++;
        end
        if (out_data_o.found !== exp_r.found) begin
          $error("found: expected %0d, got %0d", exp_r.found, out_data_o.found);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("testbench: FAIL");
    $finish;
  end

  task automatic test_reset_length();
    send_item('0, 1'b0);
    send_item('1, 1'b1);
    send_item(32'h8000_0001, 1'b1);
  endtask

  task automatic test_short_sequence();
    write_length(11'd4);
    send_item(32'd9, 1'b0);
    send_item('1, 1'b0);
    send_item('0, 1'b1);
  endtask

  task automatic test_length_clamp();
    write_length(11'd0);
    send_item(32'd5, 1'b0);
    send_item(32'd3, 1'b1);
    write_length(11'd2047);
    send_item('1, 1'b0);
    send_item('1, 1'b0);
    send_item('0, 1'b1);
  endtask

  task automatic test_ties_and_extremes();
    write_length(11'd2);
    repeat (3) send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b1);
    write_length(11'd3);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item('1, 1'b0);
    send_item('0, 1'b1);
  endtask

  task automatic test_write_mid_sequence();
    write_length(11'd3);
    send_item(32'd100, 1'b0);
    send_item(32'd1, 1'b0);
    write_length(11'd2);
    send_item(32'd7, 1'b0);
    send_item(32'd2, 1'b1);
  endtask

  task automatic test_random_sequences();
    int unsigned done_items;
    int unsigned seq_len;
    int unsigned r;
    bit          broken;
    done_items = 0;
    while (done_items < 600) begin
      if ($urandom_range(3) == 0) begin
        r = $urandom_range(99);
        if (r < 70)      write_length(LEN_W'($urandom_range(1, 8)));
        else if (r < 92) write_length(LEN_W'($urandom_range(9, 40)));
        else if (r < 97) write_length('0);
        else             write_length(LEN_W'($urandom_range(1024, 2047)));
      end
      calm    = (done_items >= 200 && done_items < 350);
      seq_len = $urandom_range(1, 3 * eff_len() + 4);
      if (seq_len > 60) seq_len = $urandom_range(1, 60);
      broken  = ($urandom_range(99) < 5);
      for (int unsigned i = 0; i < seq_len; i++) begin
        send_item(pick_height(), !broken && (i == seq_len - 1));
      end
      done_items += seq_len;
      if (broken) write_length(LEN_W'($urandom_range(1, 12)));
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    write_length(11'd3);
    hold_pending = 1'b1;
    repeat (80) send_item(pick_height(), $urandom_range(2) == 0);
    send_item(pick_height(), 1'b1);
  endtask

  task automatic test_long_window();
    if ($urandom_range(1) == 0) write_length(11'd1024);
    else write_length(LEN_W'($urandom_range(1025, 2047)));
    // rising ramp fills the candidate list, then a zero clears it
    for (int unsigned i = 0; i < 1030; i++) begin
      send_item(HEIGHT_W'(i * 4096 + $urandom_range(4095)), 1'b0);
    end
    send_item('0, 1'b0);
    repeat (60) send_item(pick_height(), 1'b0);
    send_item(pick_height(), 1'b1);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    level_config(11'd1);
    test_reset_length();
    test_short_sequence();
    test_length_clamp();
    test_ties_and_extremes();
    test_write_mid_sequence();
    test_random_sequences();
    test_backpressure();
    test_long_window();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * eff_len() + 16) @(posedge clk_i);
    $display("run covered %0d items and %0d result items (%0d with a window found)",
             items_sent, results_seen, found_seen);
    $display("over %0d window length writes, with stalls and one long hold-off", cfg_writes);
    if (fail_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
